>>> rtl/lzte_pkg.sv
`default_nettype none

package lzte_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LIMIT_W  = 13;
  localparam int unsigned PHRASE_W = 12;
  localparam int unsigned OUT_DATA_W = 24;  // phrase_id + follow_byte, byte padded

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // latch the incoming byte and last flag
    logic load_head;    // walk pointer <= first child of cursor
    logic step;         // walk pointer <= next sibling
    logic take_match;   // cursor <= walk pointer
    logic emit_match;   // load flush token
    logic emit_miss;    // load normal token
    logic ins1;         // write new node entry
    logic ins2;         // link new node under cursor, bump free id
    logic to_root;      // cursor back to root
    logic clear_dict;   // reset root list and free id
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_zero;
    logic byte_match;
    logic last;
    logic can_insert;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

>>> rtl/lzte_datapath.sv
`default_nettype none

module lzte_datapath import lzte_pkg::*; #(
  parameter int unsigned DICT_ENTRIES = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [LIMIT_W-1:0]    cfg_wr_data,
  input  wire logic [BYTE_W-1:0]     s_tdata,
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tuser,
  output logic                       m_tlast,
  input  wire ctl_cmd_t              cmd,
  output ctl_sts_t                   sts
);

  localparam int unsigned ID_W  = $clog2(DICT_ENTRIES);
  localparam int unsigned CNT_W = $clog2(DICT_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [LIMIT_W-1:0] dict_limit;
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_last;
  logic [ID_W-1:0]    cursor;
  logic [ID_W-1:0]    walk;
  logic [ID_W-1:0]    head;
  logic [ID_W-1:0]    root_child;
  logic [CNT_W-1:0]   next_free_id;

  logic [BYTE_W-1:0]  edge_mem [DICT_ENTRIES];
  logic [ID_W-1:0]    fc_mem   [DICT_ENTRIES];
  logic [ID_W-1:0]    ns_mem   [DICT_ENTRIES];
  logic [BYTE_W-1:0]  edge_rd;
  logic [ID_W-1:0]    fc_rd;
  logic [ID_W-1:0]    ns_rd;

  logic [ID_W-1:0]    new_id;
  logic [ID_W-1:0]    head_n;
  logic [ID_W-1:0]    phrase_src;
  logic [PHRASE_W-1:0] phrase_id;
  logic [PHRASE_W-1:0] out_phrase;
  logic [BYTE_W-1:0]  out_char;
  logic               can_insert;

  assign new_id = next_free_id[ID_W-1:0];
  // root's child list lives in a register so reset clears it at once
  assign head_n = (cursor == '0) ? root_child : fc_rd;

  assign can_insert = (CMP_W'(next_free_id) < CMP_W'(dict_limit)) &&
                      (CMP_W'(next_free_id) < CMP_W'(DICT_ENTRIES));

  always_ff @(posedge clk) begin
    edge_rd <= edge_mem[walk];
    ns_rd   <= ns_mem[walk];
    fc_rd   <= fc_mem[cursor];
    if (cmd.ins1) begin
      edge_mem[new_id] <= cur_byte;
      ns_mem[new_id]   <= head;
      fc_mem[new_id]   <= '0;
    end else if (cmd.ins2 && cursor != '0) begin
      fc_mem[cursor] <= new_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dict_limit   <= LIMIT_RESET;
      cursor       <= '0;
      root_child   <= '0;
      next_free_id <= CNT_W'(1);
    end else begin
      if (cfg_wr_en) begin
        dict_limit <= cfg_wr_data;
      end
      if (cmd.clear_dict) begin
        cursor       <= '0;
        root_child   <= '0;
        next_free_id <= CNT_W'(1);
      end else begin
        if (cmd.ins2) begin
          next_free_id <= next_free_id + CNT_W'(1);
          if (cursor == '0) begin
            root_child <= new_id;
          end
        end
        if (cmd.take_match) begin
          cursor <= walk;
        end else if (cmd.to_root) begin
          cursor <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_byte <= s_tdata;
      cur_last <= s_tlast;
    end
    if (cmd.load_head) begin
      head <= head_n;
      walk <= head_n;
    end else if (cmd.step) begin
      walk <= ns_rd;
    end
  end

  assign phrase_src = cmd.emit_match ? walk : cursor;

  if (ID_W >= PHRASE_W) begin : g_phrase_trunc
    assign phrase_id = phrase_src[PHRASE_W-1:0];
  end else begin : g_phrase_ext
    assign phrase_id = {{(PHRASE_W - ID_W){1'b0}}, phrase_src};
  end

  // output register, one token
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_match || cmd.emit_miss) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_match || cmd.emit_miss) begin
      out_phrase <= phrase_id;
      out_char   <= cmd.emit_miss ? cur_byte : '0;
      m_tuser    <= cmd.emit_miss;
      m_tlast    <= cur_last;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - PHRASE_W - BYTE_W){1'b0}}, out_char, out_phrase};

  assign sts.walk_zero  = (walk == '0);
  assign sts.byte_match = (edge_rd == cur_byte);
  assign sts.last       = cur_last;
  assign sts.can_insert = can_insert;
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule

`default_nettype wire

>>> rtl/lzte_ctrl.sv
`default_nettype none

module lzte_ctrl import lzte_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output ctl_cmd_t      cmd,
  input  wire ctl_sts_t sts
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_FC    = 10'b00_0000_0010,
    ST_HEAD  = 10'b00_0000_0100,
    ST_TEST  = 10'b00_0000_1000,
    ST_CMP   = 10'b00_0001_0000,
    ST_HIT   = 10'b00_0010_0000,
    ST_MISS  = 10'b00_0100_0000,
    ST_INS1  = 10'b00_1000_0000,
    ST_INS2  = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_FC;
        end
      end
      // first-child read of the cursor is in flight
      ST_FC: begin
        state_next = ST_HEAD;
      end
      ST_HEAD: begin
        cmd.load_head = 1'b1;
        state_next    = ST_TEST;
      end
      ST_TEST: begin
        state_next = sts.walk_zero ? ST_MISS : ST_CMP;
      end
      ST_CMP: begin
        if (sts.byte_match) begin
          state_next = ST_HIT;
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_TEST;
        end
      end
      ST_HIT: begin
        if (!sts.last) begin
          cmd.take_match = 1'b1;
          state_next     = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_match = 1'b1;
          cmd.clear_dict = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (sts.out_free) begin
          cmd.emit_miss = 1'b1;
          state_next    = sts.can_insert ? ST_INS1 : ST_DONE;
        end
      end
      ST_INS1: begin
        cmd.ins1   = 1'b1;
        state_next = ST_INS2;
      end
      ST_INS2: begin
        cmd.ins2   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.to_root    = 1'b1;
        cmd.clear_dict = sts.last;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/lz78_trie_encoder_core.sv
`default_nettype none

// channel    dir  signals                         request
// s_*        in   tvalid tready tdata tlast       one message byte
// m_*        out  tvalid tready tdata tuser tlast one token
// cfg_*      in   wr_en wr_data                   dict_limit write
//
// a byte passes through the first-child read and the head load, then a sibling
// walk through the edge/next-sibling memories tests and compares each sibling in
// turn; a miss emits a token and, below the limit, writes and links a new node.
// rst is synchronous: root list, cursor, free id and dict_limit reset at once.
// a token waits in the output register; the next byte is taken meanwhile and
// its own token stalls only until that register frees.
module lz78_trie_encoder_core import lzte_pkg::*; #(
  parameter int unsigned DICT_ENTRIES = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [LIMIT_W-1:0]   cfg_wr_data,   // dict_limit
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [BYTE_W-1:0]    s_tdata,       // data_byte
  input  wire logic                 s_tlast,       // last_byte
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OUT_DATA_W-1:0]     m_tdata,       // phrase_id[11:0], follow_byte[19:12]
  output logic                      m_tuser,       // has_char
  output logic                      m_tlast        // end_of_message
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lzte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  lzte_datapath #(
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cmd         (cmd),
    .sts         (sts)
  );

  // a byte is still being worked on right after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again right after a request");

  // tokens are only loaded while a byte is in progress
  a_emit_when_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_match || cmd.emit_miss) |-> !s_tready)
    else $error("token emitted while idle");

  // link step always follows the node write
  a_ins_order: assert property (@(posedge clk) disable iff (rst)
    cmd.ins2 |-> $past(cmd.ins1))
    else $error("node link without node write");

  // a pending token is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_match || cmd.emit_miss) |-> (!m_tvalid || m_tready))
    else $error("output token overwritten");

endmodule

`default_nettype wire

>>> tb/lz78_trie_encoder_core_tb.sv
`timescale 1ns / 100ps

module lz78_trie_encoder_core_tb;
  import lzte_pkg::*;

  localparam int unsigned DICT_SIZE     = 4096;
  localparam int unsigned ITEM_GOAL     = 2000;
  localparam int unsigned CALM_FROM     = 1700;
  localparam int unsigned SETTLE_CYCLES = 600;   // full 256-sibling walk plus insert
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 20000000;
  localparam int unsigned N_DIR         = 24;

  typedef struct packed {
    logic [PHRASE_W-1:0] phrase_id;
    logic [BYTE_W-1:0]   follow_byte;
    logic                has_char;
    logic                end_of_message;
  } lz_token_t;

  typedef struct packed {
    logic               cfg_wr;
    logic [LIMIT_W-1:0] cfg_val;
    logic [BYTE_W-1:0]  data_byte;
    logic               last_byte;
    logic               fixed;     // typed-in token below is the expectation
    lz_token_t          tok;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  // trie shadow
  logic [BYTE_W-1:0]  node_byte  [DICT_SIZE];
  int unsigned        node_child [DICT_SIZE];
  int unsigned        node_sib   [DICT_SIZE];
  int unsigned        cur_node;
  int unsigned        free_id;
  logic [LIMIT_W-1:0] limit_shadow;

  lz_token_t   tokens_due [$];
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  logic        long_hold = 1'b0;
  bit          hold_used = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  dir_row_t dir_rows [N_DIR] = '{
    // default limit, fresh dictionary
    '{1'b0, 13'd0,    8'h00, 1'b0, 1'b1, '{12'd0, 8'h00, 1'b1, 1'b0}},
    '{1'b0, 13'd0,    8'hFF, 1'b0, 1'b1, '{12'd0, 8'hFF, 1'b1, 1'b0}},
    '{1'b0, 13'd0,    8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 13'd0,    8'hFF, 1'b0, 1'b1, '{12'd1, 8'hFF, 1'b1, 1'b0}},
    // last byte still matching: flush token
    '{1'b0, 13'd0,    8'h00, 1'b1, 1'b1, '{12'd1, 8'h00, 1'b0, 1'b1}},
    // single-byte message after the clear
    '{1'b0, 13'd0,    8'hA5, 1'b1, 1'b1, '{12'd0, 8'hA5, 1'b1, 1'b1}},
    '{1'b0, 13'd0,    8'h5A, 1'b0, 1'b1, '{12'd0, 8'h5A, 1'b1, 1'b0}},
    '{1'b0, 13'd0,    8'h5A, 1'b0, 1'b0, '0},
    '{1'b0, 13'd0,    8'h5A, 1'b0, 1'b1, '{12'd1, 8'h5A, 1'b1, 1'b0}},
    '{1'b0, 13'd0,    8'h5A, 1'b0, 1'b0, '0},
    '{1'b0, 13'd0,    8'h5A, 1'b0, 1'b0, '0},
    // last byte missing: normal token closes the message
    '{1'b0, 13'd0,    8'h5A, 1'b1, 1'b1, '{12'd2, 8'h5A, 1'b1, 1'b1}},
    // limit 2: one node, then full
    '{1'b1, 13'd2,    8'h3C, 1'b0, 1'b1, '{12'd0, 8'h3C, 1'b1, 1'b0}},
    '{1'b0, 13'd0,    8'hC3, 1'b0, 1'b1, '{12'd0, 8'hC3, 1'b1, 1'b0}},
    '{1'b0, 13'd0,    8'hC3, 1'b0, 1'b1, '{12'd0, 8'hC3, 1'b1, 1'b0}},
    '{1'b0, 13'd0,    8'h3C, 1'b0, 1'b0, '0},
    '{1'b0, 13'd0,    8'h3C, 1'b1, 1'b1, '{12'd1, 8'h3C, 1'b1, 1'b1}},
    // limit zero and one never add a node
    '{1'b1, 13'd0,    8'h11, 1'b0, 1'b1, '{12'd0, 8'h11, 1'b1, 1'b0}},
    '{1'b0, 13'd0,    8'h11, 1'b1, 1'b1, '{12'd0, 8'h11, 1'b1, 1'b1}},
    '{1'b1, 13'd1,    8'h22, 1'b0, 1'b1, '{12'd0, 8'h22, 1'b1, 1'b0}},
    '{1'b0, 13'd0,    8'h22, 1'b1, 1'b1, '{12'd0, 8'h22, 1'b1, 1'b1}},
    // limit above capacity is clamped
    '{1'b1, 13'd8191, 8'h80, 1'b0, 1'b1, '{12'd0, 8'h80, 1'b1, 1'b0}},
    '{1'b0, 13'd0,    8'h80, 1'b0, 1'b0, '0},
    '{1'b0, 13'd0,    8'h80, 1'b1, 1'b1, '{12'd1, 8'h80, 1'b1, 1'b1}}
  };

  lz78_trie_encoder_core #(
    .DICT_ENTRIES(DICT_SIZE)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned lookup_child(int unsigned node, logic [BYTE_W-1:0] b);
    int unsigned n;
    if (node >= DICT_SIZE) return 0;
    n = node_child[node];
    for (int unsigned guard = 0; guard < DICT_SIZE; guard++) begin
      if (n == 0 || n >= DICT_SIZE) return 0;
      if (node_byte[n] == b) return n;
      n = node_sib[n];
    end
    return 0;
  endfunction

  function automatic bit encode_byte(input logic [BYTE_W-1:0] b, input logic last_byte,
                                     output lz_token_t tok);
    int unsigned child;
    int unsigned cap;
    cap = (32'(limit_shadow) > DICT_SIZE) ? DICT_SIZE : 32'(limit_shadow);
    child = lookup_child(cur_node, b);
    tok = '0;
    encode_byte = 1'b0;
    if (child != 0) begin
      cur_node = child;
      if (last_byte) begin
        tok.phrase_id = child[PHRASE_W-1:0];
        tok.end_of_message = 1'b1;
        encode_byte = 1'b1;
      end
    end else begin
      tok.phrase_id = cur_node[PHRASE_W-1:0];
      tok.follow_byte = b;
      tok.has_char = 1'b1;
      tok.end_of_message = last_byte;
      encode_byte = 1'b1;
      if (free_id < cap) begin
        // new child goes to the head of the parent's sibling list
        node_byte[free_id] = b;
        node_child[free_id] = 0;
        node_sib[free_id] = node_child[cur_node];
        node_child[cur_node] = free_id;
        free_id++;
      end
      cur_node = 0;
    end
    if (last_byte) begin
      cur_node = 0;
      free_id = 1;
      node_child[0] = 0;
    end
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (err_count < 40)
      $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  task automatic check_token();
    lz_token_t want;
    if (tokens_due.size() == 0) begin
      note_mismatch("token with none pending", 32'(m_tdata), 0);
      return;
    end
    want = tokens_due.pop_front();
    if (m_tdata[PHRASE_W-1:0] != want.phrase_id)
      note_mismatch("phrase_id", 32'(m_tdata[PHRASE_W-1:0]), 32'(want.phrase_id));
    if (m_tdata[PHRASE_W +: BYTE_W] != want.follow_byte)
      note_mismatch("follow_byte", 32'(m_tdata[PHRASE_W +: BYTE_W]), 32'(want.follow_byte));
    if (m_tuser != want.has_char)
      note_mismatch("has_char", 32'(m_tuser), 32'(want.has_char));
    if (m_tlast != want.end_of_message)
      note_mismatch("end_of_message", 32'(m_tlast), 32'(want.end_of_message));
  endtask

  // token sink: random stalls, plus one long hold that backs the block up
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_token();
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last_byte,
                           input logic fixed, input lz_token_t typed_tok);
    int unsigned gap;
    lz_token_t tok;
    bit produced;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last_byte;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (items_sent >= CALM_FROM) calm = 1'b1;
    produced = encode_byte(b, last_byte, tok);
    if (fixed) tokens_due.push_back(typed_tok);
    else if (produced) tokens_due.push_back(tok);
  endtask

  // stop offering, wait out every pending token and any walk still running
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    limit_shadow = val;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_message(input int unsigned min_len);
    int unsigned len;
    int unsigned span;
    int unsigned base;
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 5))
      0: span = 1;
      1: span = 2;
      2: span = 3;
      3: span = 4;
      4: span = 16;
      default: span = 256;
    endcase
    // random long lengths only on narrow alphabets, so phrases grow deep; min_len can lengthen any
    if (span <= 16 && $urandom_range(0, 9) == 0) len = $urandom_range(60, 300);
    else len = $urandom_range(1, 30);
    if (len < min_len) len = min_len;
    base = $urandom_range(0, 255);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0) b = BYTE_W'($urandom_range(0, 255));
      else b = BYTE_W'(base + $urandom_range(0, span - 1));
      send_byte(b, k == len - 1, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned msgs;
    for (int unsigned i = 0; i < DICT_SIZE; i++) begin
      node_byte[i] = '0;
      node_child[i] = 0;
      node_sib[i] = 0;
    end
    cur_node = 0;
    free_id = 1;
    limit_shadow = LIMIT_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int unsigned i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].cfg_wr) begin
        settle_block();
        write_limit(dir_rows[i].cfg_val);
      end
      send_byte(dir_rows[i].data_byte, dir_rows[i].last_byte, dir_rows[i].fixed,
                dir_rows[i].tok);
    end

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      settle_block();
      if (phase == 0) begin
        // limit 1: every byte is a token, so the long hold fills the block
        write_limit(13'd1);
        long_hold <= 1'b1;
        send_message(60);
      end else begin
        case ($urandom_range(0, 8))
          0: write_limit(13'd4096);
          1: write_limit(13'd8191);
          2: write_limit(13'd0);
          3: write_limit(13'd2);
          4: write_limit(13'd3);
          5: write_limit(LIMIT_W'($urandom_range(1, 4096)));
          6: write_limit(LIMIT_W'($urandom_range(0, 8191)));
          default: write_limit(LIMIT_W'($urandom_range(4, 64)));
        endcase
      end
      msgs = $urandom_range(1, 6);
      repeat (msgs) begin
        if (items_sent < ITEM_GOAL) send_message(1);
      end
      phase++;
    end

    settle_block();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
